FILE: hdl/lrpf_pkg.sv
package lrpf_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
  localparam int STORE_DEPTH   = ROW_BYTES * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);

  localparam int COORD_W = 12;
  localparam int DELTA_W = COORD_W;
  localparam int D_W     = COORD_W + 3;
  localparam int RADDR_W = 16;
  localparam int COUNT_W = 10;
  localparam int WORD_W  = 32;

  localparam logic [1:0] REQ_DRAW  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

FILE: hdl/lrpf_req_if.sv
interface lrpf_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     req_type;
  logic signed [lrpf_pkg::COORD_W-1:0] start_x;
  logic signed [lrpf_pkg::COORD_W-1:0] start_y;
  logic signed [lrpf_pkg::COORD_W-1:0] end_x;
  logic signed [lrpf_pkg::COORD_W-1:0] end_y;
  logic [3:0]                     pen_color;
  logic [lrpf_pkg::RADDR_W-1:0]   read_address;

  modport source (output valid, req_type, start_x, start_y, end_x, end_y, pen_color,
                  read_address, input ready);
  modport sink (input valid, req_type, start_x, start_y, end_x, end_y, pen_color,
                read_address, output ready);
endinterface

FILE: hdl/lrpf_rsp_if.sv
interface lrpf_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lrpf_pkg::WORD_W-1:0]  plane_bytes;
  logic [lrpf_pkg::COUNT_W-1:0] pixels_drawn;

  modport source (output valid, plane_bytes, pixels_drawn, input ready);
  modport sink (input valid, plane_bytes, pixels_drawn, output ready);
endinterface

FILE: hdl/line_raster_to_planar_framebuffer.sv
// Line rasterizer into a 640x480 planar 4-bit framebuffer held in one
// single-port-write, single-port-read memory of 38400 32-bit words (plane k in
// bits 8k+7..8k). One item is served at a time and every item returns exactly
// one result. After reset the block sweeps the memory to zero before accepting
// its first item. A draw walks the major axis one position per step with
// Bresenham: a setup state and an ordering state, then for each on-screen
// pixel a plot state and a write state (read-modify-write of its word) and for
// each off-screen position the plot state alone, then the done state hands over
// the result. A read passes through a read state and a read-data state, and a
// clear sweeps the whole memory, each before the done state.
// A result is held in an output register, so the next item is accepted while
// it waits; that item then stalls in its final state until the result is taken.
module line_raster_to_planar_framebuffer (
  input  logic clk,
  input  logic rst,
  lrpf_req_if.sink   req,
  lrpf_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_SETUP, S_ORDER, S_PLOT, S_WRITE, S_READ, S_RDATA, S_DONE
  } state_t;

  state_t state;

  lrpf_pkg::coord_t x1, y1, x2, y2;
  lrpf_pkg::coord_t ma, mi, ma_end, mi_end;
  logic [lrpf_pkg::DELTA_W-1:0] dmaj, dmin;
  logic signed [lrpf_pkg::D_W-1:0] d, d_inc, d_dec;
  logic                          swap, mi_up, sweep_reply;
  logic [3:0]                    color;
  logic [lrpf_pkg::RADDR_W-1:0]  rd_addr;
  lrpf_pkg::addr_t               sweep_addr, pix_waddr;
  lrpf_pkg::word_t               fill;
  logic [2:0]                    pix_bit;
  logic [lrpf_pkg::COUNT_W-1:0]  count;
  lrpf_pkg::word_t               res_bytes;
  logic [lrpf_pkg::COUNT_W-1:0]  res_count;
  logic                          out_valid;
  lrpf_pkg::word_t               out_bytes;
  logic [lrpf_pkg::COUNT_W-1:0]  out_count;

  // memory port
  logic            mem_we;
  lrpf_pkg::addr_t mem_waddr, mem_raddr;
  lrpf_pkg::word_t mem_wdata, mem_rdata;

  lrpf_fb_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // setup arithmetic
  logic signed [lrpf_pkg::COORD_W:0] dx_s, dy_s;
  logic [lrpf_pkg::DELTA_W-1:0]      dx_abs, dy_abs;
  logic                              x_major;

  always_comb begin
    dx_s    = {x2[lrpf_pkg::COORD_W-1], x2} - {x1[lrpf_pkg::COORD_W-1], x1};
    dy_s    = {y2[lrpf_pkg::COORD_W-1], y2} - {y1[lrpf_pkg::COORD_W-1], y1};
    dx_abs  = dx_s[lrpf_pkg::COORD_W] ? lrpf_pkg::DELTA_W'(-dx_s)
                                      : lrpf_pkg::DELTA_W'(dx_s);
    dy_abs  = dy_s[lrpf_pkg::COORD_W] ? lrpf_pkg::DELTA_W'(-dy_s)
                                      : lrpf_pkg::DELTA_W'(dy_s);
    x_major = dx_abs > dy_abs;
  end

  // current pixel
  lrpf_pkg::coord_t px, py;
  logic             on_screen;
  lrpf_pkg::addr_t  pix_addr;

  always_comb begin
    px = swap ? mi : ma;
    py = swap ? ma : mi;
    on_screen = !px[lrpf_pkg::COORD_W-1] && !py[lrpf_pkg::COORD_W-1] &&
                ({1'b0, px} < (lrpf_pkg::COORD_W+1)'(lrpf_pkg::SCREEN_WIDTH)) &&
                ({1'b0, py} < (lrpf_pkg::COORD_W+1)'(lrpf_pkg::SCREEN_HEIGHT));
    pix_addr  = lrpf_pkg::ADDR_W'(px[lrpf_pkg::COORD_W-2:3]) +
                lrpf_pkg::ADDR_W'(py[lrpf_pkg::COORD_W-2:0]) *
                lrpf_pkg::ADDR_W'(lrpf_pkg::ROW_BYTES);
  end

  // Bresenham step
  logic                            last;
  lrpf_pkg::coord_t                ma_step, mi_step;
  logic signed [lrpf_pkg::D_W-1:0] d_step;

  always_comb begin
    last    = (ma == ma_end);
    ma_step = ma + lrpf_pkg::coord_t'(1);
    if (d[lrpf_pkg::D_W-1]) begin
      mi_step = mi;
      d_step  = d + d_inc;
    end else begin
      mi_step = mi_up ? mi + lrpf_pkg::coord_t'(1) : mi - lrpf_pkg::coord_t'(1);
      d_step  = d + d_dec;
    end
  end

  // pixel merge
  lrpf_pkg::word_t merged;

  always_comb begin
    merged = mem_rdata;
    for (int k = 0; k < 4; k++) begin
      merged[{k[1:0], pix_bit}] = color[k];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = fill;
    mem_raddr = pix_addr;
    unique case (state)
      S_SWEEP: mem_we = 1'b1;
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = pix_waddr;
        mem_wdata = merged;
      end
      S_READ:  mem_raddr = lrpf_pkg::ADDR_W'(rd_addr);
      default: ;
    endcase
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.plane_bytes  = out_bytes;
  assign rsp.pixels_drawn = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_addr  <= '0;
      sweep_reply <= 1'b0;
      fill        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
        out_bytes <= res_bytes;
        out_count <= res_count;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + lrpf_pkg::addr_t'(1);
          if (sweep_addr == lrpf_pkg::ADDR_W'(lrpf_pkg::STORE_DEPTH - 1)) begin
            state <= sweep_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            x1        <= req.start_x;
            y1        <= req.start_y;
            x2        <= req.end_x;
            y2        <= req.end_y;
            color     <= req.pen_color;
            rd_addr   <= req.read_address;
            res_bytes <= '0;
            res_count <= '0;
            count     <= '0;
            case (req.req_type)
              lrpf_pkg::REQ_DRAW: state <= S_SETUP;
              lrpf_pkg::REQ_READ: state <= S_READ;
              lrpf_pkg::REQ_CLEAR: begin
                fill        <= {{8{req.pen_color[3]}}, {8{req.pen_color[2]}},
                                {8{req.pen_color[1]}}, {8{req.pen_color[0]}}};
                sweep_addr  <= '0;
                sweep_reply <= 1'b1;
                state       <= S_SWEEP;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SETUP: begin
          swap <= !x_major;
          if (x_major) begin
            ma <= x1; mi <= y1; ma_end <= x2; mi_end <= y2;
            dmaj <= dx_abs; dmin <= dy_abs;
          end else begin
            ma <= y1; mi <= x1; ma_end <= y2; mi_end <= x2;
            dmaj <= dy_abs; dmin <= dx_abs;
          end
          state <= S_ORDER;
        end
        S_ORDER: begin
          if (ma > ma_end) begin
            ma <= ma_end; mi <= mi_end; ma_end <= ma; mi_end <= mi;
            mi_up <= (mi > mi_end);
          end else begin
            mi_up <= (mi_end > mi);
          end
          d     <= lrpf_pkg::D_W'({dmin, 1'b0}) - lrpf_pkg::D_W'(dmaj);
          d_inc <= lrpf_pkg::D_W'({dmin, 1'b0});
          d_dec <= lrpf_pkg::D_W'({dmin, 1'b0}) - lrpf_pkg::D_W'({dmaj, 1'b0});
          state <= S_PLOT;
        end
        S_PLOT: begin
          pix_waddr <= pix_addr;
          pix_bit   <= ~px[2:0];
          if (on_screen) begin
            state <= S_WRITE;
          end else if (last) begin
            res_count <= count;
            state     <= S_DONE;
          end else begin
            ma <= ma_step; mi <= mi_step; d <= d_step;
          end
        end
        S_WRITE: begin
          if (last) begin
            res_count <= (&count) ? count : count + lrpf_pkg::COUNT_W'(1);
            state     <= S_DONE;
          end else begin
            ma <= ma_step; mi <= mi_step; d <= d_step;
            state <= S_PLOT;
          end
          if (!(&count)) begin
            count <= count + lrpf_pkg::COUNT_W'(1);
          end
        end
        S_READ: state <= S_RDATA;
        S_RDATA: begin
          if ((lrpf_pkg::RADDR_W+1)'(rd_addr) <
              (lrpf_pkg::RADDR_W+1)'(lrpf_pkg::STORE_DEPTH)) begin
            res_bytes <= mem_rdata;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/lrpf_fb_mem.sv
module lrpf_fb_mem (
  input  logic            clk,
  input  logic            we,
  input  lrpf_pkg::addr_t waddr,
  input  lrpf_pkg::word_t wdata,
  input  lrpf_pkg::addr_t raddr,
  output lrpf_pkg::word_t rdata
);

  lrpf_pkg::word_t mem [lrpf_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
